### hdl/bfsh_pkg.sv
package bfsh_pkg;

   localparam int CSR_AW = 2;
   localparam int CSR_DW = 32;

   localparam logic [CSR_AW-1:0] CSR_BIT_COUNT   = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_PROBE_COUNT = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_CAPACITY    = 2'd2;

   localparam logic [1:0] MODE_ADD   = 2'd0;
   localparam logic [1:0] MODE_TEST  = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   localparam int BC_W  = 17;
   localparam int PC_W  = 5;
   localparam int MIN_PROBES = 2;

   localparam logic [31:0] SHA_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] SHA_IV [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   typedef struct packed {
      logic        init;
      logic        wr;
      logic        fill;
      logic        start;
      logic [5:0]  pos;
      logic [7:0]  data;
      logic        mark;
      logic        with_len;
      logic [63:0] bits;
   } sha_cmd_type;

   typedef struct packed {
      logic        done;
      logic [31:0] h0;
      logic [31:0] h1;
   } sha_sts_type;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] bswap(input logic [31:0] x);
      return {x[7:0], x[15:8], x[23:16], x[31:24]};
   endfunction

endpackage

### hdl/bfsh_sha.sv
module bfsh_sha (
   input  logic                 clock,
   input  logic                 reset,
   input  bfsh_pkg::sha_cmd_type cmd,
   output bfsh_pkg::sha_sts_type sts
);
   import bfsh_pkg::*;

   logic [31:0] hv_ff [8];
   logic [31:0] st_ff [8];
   logic [31:0] w_ff  [16];
   logic [5:0]  rnd_ff;
   logic        run_ff;
   logic        fin_ff;
   logic        done_ff;

   logic [31:0] t1, t2, s0, s1, wn;
   logic [1:0]  lane;

   always_comb begin
      t1 = st_ff[7] + (rotr(st_ff[4], 6) ^ rotr(st_ff[4], 11) ^ rotr(st_ff[4], 25))
           + ((st_ff[4] & st_ff[5]) ^ (~st_ff[4] & st_ff[6])) + SHA_K[rnd_ff] + w_ff[0];
      t2 = (rotr(st_ff[0], 2) ^ rotr(st_ff[0], 13) ^ rotr(st_ff[0], 22))
           + ((st_ff[0] & st_ff[1]) ^ (st_ff[0] & st_ff[2]) ^ (st_ff[1] & st_ff[2]));
      s0 = rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1 = rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
      wn = w_ff[0] + s0 + w_ff[9] + s1;
      lane = ~cmd.pos[1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         rnd_ff  <= '0;
         for (int i = 0; i < 8; i++) hv_ff[i] <= SHA_IV[i];
      end else begin
         done_ff <= 1'b0;
         if (cmd.init) begin
            for (int i = 0; i < 8; i++) hv_ff[i] <= SHA_IV[i];
         end
         if (cmd.start) begin
            for (int i = 0; i < 8; i++) st_ff[i] <= hv_ff[i];
            rnd_ff <= '0;
            run_ff <= 1'b1;
         end else if (run_ff) begin
            st_ff[0] <= t1 + t2;
            st_ff[1] <= st_ff[0];
            st_ff[2] <= st_ff[1];
            st_ff[3] <= st_ff[2];
            st_ff[4] <= st_ff[3] + t1;
            st_ff[5] <= st_ff[4];
            st_ff[6] <= st_ff[5];
            st_ff[7] <= st_ff[6];
            for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
            w_ff[15] <= wn;
            rnd_ff <= rnd_ff + 6'd1;
            if (rnd_ff == 6'd63) begin
               run_ff <= 1'b0;
               fin_ff <= 1'b1;
            end
         end else if (fin_ff) begin
            for (int i = 0; i < 8; i++) hv_ff[i] <= hv_ff[i] + st_ff[i];
            fin_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
         if (cmd.wr) begin
            w_ff[cmd.pos[5:2]][{lane, 3'b000} +: 8] <= cmd.data;
         end
         if (cmd.fill) begin
            for (int p = 0; p < 64; p++) begin
               if (6'(p) == cmd.pos && cmd.mark) begin
                  w_ff[p/4][31-8*(p%4) -: 8] <= 8'h80;
               end else if (6'(p) >= cmd.pos) begin
                  w_ff[p/4][31-8*(p%4) -: 8] <= 8'h00;
               end
            end
            if (cmd.with_len) begin
               w_ff[14] <= cmd.bits[63:32];
               w_ff[15] <= cmd.bits[31:0];
            end
         end
      end
   end

   assign sts.done = done_ff;
   assign sts.h0   = hv_ff[0];
   assign sts.h1   = hv_ff[1];

endmodule

### hdl/bfsh_mod.sv
module bfsh_mod (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [31:0]                dividend,
   input  logic [bfsh_pkg::BC_W-1:0]  divisor,
   output logic                       done,
   output logic [bfsh_pkg::BC_W-1:0]  remainder
);
   import bfsh_pkg::*;

   logic [31:0]     q_ff;
   logic [BC_W-1:0] r_ff;
   logic [4:0]      cnt_ff;
   logic            run_ff;
   logic            done_ff;
   logic [BC_W:0]   r2;

   assign r2 = {r_ff, q_ff[31]};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            q_ff   <= dividend;
            r_ff   <= '0;
            cnt_ff <= '0;
            run_ff <= 1'b1;
         end else if (run_ff) begin
            q_ff <= {q_ff[30:0], 1'b0};
            if (r2 >= {1'b0, divisor}) r_ff <= BC_W'(r2 - {1'b0, divisor});
            else                      r_ff <= r2[BC_W-1:0];
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done      = done_ff;
   assign remainder = r_ff;

endmodule

### hdl/bloom_filter_sha256_double_hash.sv
// Channel  Ports                    Contents
// req      req_tvalid/tready        tdata key_byte, tuser mode, tlast last
// rsp      rsp_tvalid/tready        tdata member, accepted, item_count
// csr      csr_we/addr/wdata        bit_count, probe_count, capacity
// A key byte is taken while idle; a byte that fills a 64-byte block starts a compression,
// one SHA-256 round per cycle on the shared round unit.
// The last byte adds one or two compressions, then per probe a division in the
// bit-serial modulo unit; clear sweeps the whole store.
// After reset the store is swept clear before req_tready rises.
// A result holds on rsp until taken; no byte is taken meanwhile.
module bloom_filter_sha256_double_hash #(
   parameter int MAX_BITS   = 65536,
   parameter int MAX_PROBES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // key_byte
   input  logic [1:0]                    req_tuser,   // mode
   input  logic                          req_tlast,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [39:0]                   rsp_tdata,   // member, accepted, item_count, zero fill
   input  logic                          csr_we,
   input  logic [bfsh_pkg::CSR_AW-1:0]   csr_addr,
   input  logic [bfsh_pkg::CSR_DW-1:0]   csr_wdata
);
   import bfsh_pkg::*;

   localparam int IW = $clog2(MAX_BITS);
   localparam int XW = (IW > BC_W) ? IW : BC_W;
   localparam int KW = $clog2(MAX_PROBES + 1);
   localparam int CW = (KW > PC_W) ? KW : PC_W;

   typedef enum logic [10:0] {
      S_IDLE   = 11'b000_0000_0001,
      S_CSTART = 11'b000_0000_0010,
      S_CWAIT  = 11'b000_0000_0100,
      S_PAD    = 11'b000_0000_1000,
      S_PAD2   = 11'b000_0001_0000,
      S_HASHED = 11'b000_0010_0000,
      S_PROBE  = 11'b000_0100_0000,
      S_PWAIT  = 11'b000_1000_0000,
      S_PCHK   = 11'b001_0000_0000,
      S_CLEAR  = 11'b010_0000_0000,
      S_RESP   = 11'b100_0000_0000
   } state_type;

   state_type        state_ff, state_in;
   logic [BC_W-1:0]  bc_ff;
   logic [PC_W-1:0]  pc_ff;
   logic [31:0]      cap_ff;
   logic [31:0]      items_ff, items_in;
   logic [63:0]      len_ff, len_in;
   logic [1:0]       mode_ff, mode_in;
   logic             lastp_ff, lastp_in;
   logic             pad2_ff, pad2_in;
   logic             finb_ff, finb_in;
   logic [31:0]      x_ff, x_in;
   logic [31:0]      h2_ff, h2_in;
   logic [KW-1:0]    pi_ff, pi_in;
   logic             mem_ff, mem_in;
   logic             acc_ff, acc_in;
   logic             clrsp_ff, clrsp_in;
   logic [IW-1:0]    clr_ff, clr_in;
   logic             rvalid_ff, rvalid_in;
   logic             rd_ff;
   logic             fb_mem [MAX_BITS];

   sha_cmd_type      cmd;
   sha_sts_type      sts;
   logic             mod_start, mod_done;
   logic [BC_W-1:0]  m_eff, rem;
   logic [XW-1:0]    rem_x;
   logic [IW-1:0]    idx;
   logic [CW-1:0]    k_eff;
   logic             last_probe;
   logic             we;
   logic [IW-1:0]    waddr;
   logic             wbit;
   logic             re;
   logic [63:0]      len_inc;

   bfsh_sha u_sha (.clock(clock), .reset(reset), .cmd(cmd), .sts(sts));

   bfsh_mod u_mod (
      .clock(clock), .reset(reset), .start(mod_start), .dividend(x_ff),
      .divisor(m_eff), .done(mod_done), .remainder(rem)
   );

   always_comb begin
      if (bc_ff == '0)                               m_eff = BC_W'(1);
      else if ({15'd0, bc_ff} > 32'(MAX_BITS))       m_eff = BC_W'(MAX_BITS);
      else                                           m_eff = bc_ff;
      if ({27'd0, pc_ff} < 32'(MIN_PROBES))          k_eff = CW'(MIN_PROBES);
      else if ({27'd0, pc_ff} > 32'(MAX_PROBES))     k_eff = CW'(MAX_PROBES);
      else                                           k_eff = CW'(pc_ff);
      rem_x = XW'(rem);
      idx   = rem_x[IW-1:0];
      last_probe = (CW'(pi_ff) + CW'(1)) == k_eff;
      len_inc = len_ff + 64'd1;
   end

   always_comb begin
      state_in  = state_ff;
      items_in  = items_ff;
      len_in    = len_ff;
      mode_in   = mode_ff;
      lastp_in  = lastp_ff;
      pad2_in   = pad2_ff;
      finb_in   = finb_ff;
      x_in      = x_ff;
      h2_in     = h2_ff;
      pi_in     = pi_ff;
      mem_in    = mem_ff;
      acc_in    = acc_ff;
      clrsp_in  = clrsp_ff;
      clr_in    = clr_ff;
      rvalid_in = rvalid_ff;
      cmd       = '0;
      cmd.pos   = len_ff[5:0];
      cmd.data  = req_tdata;
      cmd.bits  = {len_ff[60:0], 3'b000};
      mod_start = 1'b0;
      we        = 1'b0;
      waddr     = idx;
      wbit      = 1'b1;
      re        = 1'b0;
      req_tready = (state_ff == S_IDLE);

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.wr   = 1'b1;
               len_in   = len_inc;
               mode_in  = req_tuser;
               lastp_in = req_tlast;
               finb_in  = 1'b0;
               pad2_in  = 1'b0;
               if (len_inc[5:0] == 6'd0) state_in = S_CSTART;
               else if (req_tlast)       state_in = S_PAD;
            end
         end
         S_CSTART: begin
            cmd.start = 1'b1;
            state_in  = S_CWAIT;
         end
         S_CWAIT: begin
            if (sts.done) begin
               if (finb_ff)       state_in = S_HASHED;
               else if (pad2_ff)  state_in = S_PAD2;
               else if (lastp_ff) state_in = S_PAD;
               else               state_in = S_IDLE;
            end
         end
         S_PAD: begin
            cmd.fill     = 1'b1;
            cmd.mark     = 1'b1;
            cmd.with_len = (len_ff[5:0] < 6'd56);
            finb_in      = (len_ff[5:0] < 6'd56);
            pad2_in      = (len_ff[5:0] >= 6'd56);
            lastp_in     = 1'b0;
            state_in     = S_CSTART;
         end
         S_PAD2: begin
            cmd.fill     = 1'b1;
            cmd.pos      = 6'd0;
            cmd.with_len = 1'b1;
            finb_in      = 1'b1;
            pad2_in      = 1'b0;
            state_in     = S_CSTART;
         end
         S_HASHED: begin
            x_in     = bswap(sts.h0);
            h2_in    = bswap(sts.h1);
            cmd.init = 1'b1;
            len_in   = '0;
            pi_in    = '0;
            mem_in   = 1'b0;
            acc_in   = 1'b0;
            priority if (mode_ff == MODE_ADD && items_ff < cap_ff) begin
               acc_in   = 1'b1;
               state_in = S_PROBE;
            end else if (mode_ff == MODE_TEST) begin
               mem_in   = 1'b1;
               state_in = S_PROBE;
            end else if (mode_ff == MODE_CLEAR) begin
               clr_in   = '0;
               clrsp_in = 1'b1;
               state_in = S_CLEAR;
            end else begin
               rvalid_in = 1'b1;
               state_in  = S_RESP;
            end
         end
         S_PROBE: begin
            mod_start = 1'b1;
            state_in  = S_PWAIT;
         end
         S_PWAIT: begin
            if (mod_done) begin
               if (acc_ff) begin
                  we = 1'b1;
                  if (last_probe) begin
                     items_in  = items_ff + 32'd1;
                     rvalid_in = 1'b1;
                     state_in  = S_RESP;
                  end else begin
                     pi_in    = pi_ff + KW'(1);
                     x_in     = x_ff + h2_ff;
                     state_in = S_PROBE;
                  end
               end else begin
                  re       = 1'b1;
                  state_in = S_PCHK;
               end
            end
         end
         S_PCHK: begin
            mem_in = mem_ff & rd_ff;
            if (last_probe) begin
               rvalid_in = 1'b1;
               state_in  = S_RESP;
            end else begin
               pi_in    = pi_ff + KW'(1);
               x_in     = x_ff + h2_ff;
               state_in = S_PROBE;
            end
         end
         S_CLEAR: begin
            we     = 1'b1;
            waddr  = clr_ff;
            wbit   = 1'b0;
            clr_in = clr_ff + IW'(1);
            if (clr_ff == {IW{1'b1}}) begin
               if (clrsp_ff) begin
                  items_in  = '0;
                  rvalid_in = 1'b1;
                  state_in  = S_RESP;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_RESP: begin
            if (rsp_tready) begin
               rvalid_in = 1'b0;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) fb_mem[waddr] <= wbit;
      if (re) rd_ff <= fb_mem[idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         clr_ff    <= '0;
         clrsp_ff  <= 1'b0;
         items_ff  <= '0;
         len_ff    <= '0;
         lastp_ff  <= 1'b0;
         pad2_ff   <= 1'b0;
         finb_ff   <= 1'b0;
         rvalid_ff <= 1'b0;
         bc_ff     <= BC_W'(65536);
         pc_ff     <= PC_W'(7);
         cap_ff    <= 32'd4096;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         clrsp_ff  <= clrsp_in;
         items_ff  <= items_in;
         len_ff    <= len_in;
         lastp_ff  <= lastp_in;
         pad2_ff   <= pad2_in;
         finb_ff   <= finb_in;
         rvalid_ff <= rvalid_in;
         if (csr_we) begin
            unique case (csr_addr)
               CSR_BIT_COUNT:   bc_ff  <= csr_wdata[BC_W-1:0];
               CSR_PROBE_COUNT: pc_ff  <= csr_wdata[PC_W-1:0];
               CSR_CAPACITY:    cap_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      x_ff    <= x_in;
      h2_ff   <= h2_in;
      pi_ff   <= pi_in;
      mem_ff  <= mem_in;
      acc_ff  <= acc_in;
   end

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = {6'd0, items_ff, acc_ff, mem_ff};

endmodule

### tb/bloom_filter_sha256_double_hash_test.sv
`timescale 1ns / 100ps

module bloom_filter_sha256_double_hash_test;
   import bfsh_pkg::*;

   localparam logic [1:0] MODE_NOP = 2'd3;
   localparam int FILTER_MAX = 65536;
   localparam int PROBE_MAX = 16;
   localparam int SETTLE_CYCLES = 300;

   typedef struct {
      logic [1:0] mode;
      logic [7:0] data;
      logic       last;
   } key_word_type;

   typedef struct {
      logic        member;
      logic        accepted;
      logic [31:0] count;
   } lookup_result_type;

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] HASH_START [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // key_byte
   logic [1:0]  req_tuser = '0;   // mode
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // member, accepted, item_count, zero fill
   logic              csr_we = 1'b0;
   logic [CSR_AW-1:0] csr_addr = '0;
   logic [CSR_DW-1:0] csr_wdata = '0;

   bloom_filter_sha256_double_hash dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   key_word_type      key_words[$];
   lookup_result_type lookup_q[$];
   int             send_idle_pct = 0;
   int             recv_stall_pct = 0;
   int             mismatch_count = 0;

   // filter model state
   bit          filter_map [FILTER_MAX];
   logic [31:0] keys_added = '0;
   logic [31:0] run_hash [8];
   logic [7:0]  msg_block [64];
   logic [63:0] msg_bytes = '0;
   logic [16:0] cfg_bits = 17'd65536;
   logic [4:0]  cfg_probes = 5'd7;
   logic [31:0] cfg_capacity = 32'd4096;
   logic [31:0] work_h [8];
   logic [7:0]  pad_blk [64];

   int added_seed [$];
   int added_len [$];

   initial for (int i = 0; i < 8; i++) run_hash[i] = HASH_START[i];

   function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic void compress_block();
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, hh, t1, t2, s0, s1;
      for (int i = 0; i < 16; i++)
         w[i] = {pad_blk[4*i], pad_blk[4*i+1], pad_blk[4*i+2], pad_blk[4*i+3]};
      for (int i = 16; i < 64; i++) begin
         s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
         s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
         w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      a = work_h[0]; b = work_h[1]; c = work_h[2]; d = work_h[3];
      e = work_h[4]; f = work_h[5]; g = work_h[6]; hh = work_h[7];
      for (int i = 0; i < 64; i++) begin
         t1 = hh + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
              + ROUND_K[i] + w[i];
         t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) ^ 32'h0;
         t2 = t2 + ((a & b) ^ (a & c) ^ (b & c));
         hh = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
      end
      work_h[0] += a; work_h[1] += b; work_h[2] += c; work_h[3] += d;
      work_h[4] += e; work_h[5] += f; work_h[6] += g; work_h[7] += hh;
   endfunction

   function automatic void hash_absorb(input logic [7:0] data);
      msg_block[msg_bytes[5:0]] = data;
      msg_bytes++;
      if (msg_bytes[5:0] == 6'd0) begin
         for (int i = 0; i < 8; i++) work_h[i] = run_hash[i];
         for (int i = 0; i < 64; i++) pad_blk[i] = msg_block[i];
         compress_block();
         for (int i = 0; i < 8; i++) run_hash[i] = work_h[i];
      end
   endfunction

   function automatic void hash_close(output logic [31:0] h1, output logic [31:0] h2);
      int          pos;
      logic [63:0] nbits;
      pos = msg_bytes[5:0];
      nbits = msg_bytes << 3;
      for (int i = 0; i < 8; i++) work_h[i] = run_hash[i];
      for (int i = 0; i < 64; i++) pad_blk[i] = (i < pos) ? msg_block[i] : 8'h00;
      pad_blk[pos] = 8'h80;
      if (pos >= 56) begin
         compress_block();
         for (int i = 0; i < 64; i++) pad_blk[i] = 8'h00;
      end
      for (int i = 0; i < 8; i++) pad_blk[56+i] = nbits[63-8*i -: 8];
      compress_block();
      h1 = {work_h[0][7:0], work_h[0][15:8], work_h[0][23:16], work_h[0][31:24]};
      h2 = {work_h[1][7:0], work_h[1][15:8], work_h[1][23:16], work_h[1][31:24]};
      for (int i = 0; i < 8; i++) run_hash[i] = HASH_START[i];
      msg_bytes = '0;
   endfunction

   function automatic void filter_accept(input key_word_type kw);
      logic [31:0]       h1, h2, idx, m;
      int                k;
      lookup_result_type r;
      hash_absorb(kw.data);
      if (!kw.last) return;
      hash_close(h1, h2);
      m = (cfg_bits == 0) ? 32'd1 : (cfg_bits > FILTER_MAX) ? FILTER_MAX : cfg_bits;
      k = (cfg_probes < MIN_PROBES) ? MIN_PROBES : (cfg_probes > PROBE_MAX) ? PROBE_MAX
          : cfg_probes;
      r.member = 1'b0;
      r.accepted = 1'b0;
      case (kw.mode)
         MODE_ADD: begin
            if (keys_added < cfg_capacity) begin
               for (int i = 0; i < k; i++) begin
                  idx = (h1 + i * h2) % m;
                  filter_map[idx] = 1'b1;
               end
               keys_added++;
               r.accepted = 1'b1;
            end
         end
         MODE_TEST: begin
            r.member = 1'b1;
            for (int i = 0; i < k; i++) begin
               idx = (h1 + i * h2) % m;
               if (!filter_map[idx]) r.member = 1'b0;
            end
         end
         MODE_CLEAR: begin
            foreach (filter_map[i]) filter_map[i] = 1'b0;
            keys_added = '0;
         end
         default: ;
      endcase
      r.count = keys_added;
      lookup_q.push_back(r);
   endfunction

   initial forever #1 clock = ~clock;

   always @(posedge clock) begin
      key_word_type kw;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            kw.mode = req_tuser;
            kw.data = req_tdata;
            kw.last = req_tlast;
            filter_accept(kw);
         end
         if (!req_tvalid || req_tready) begin
            if (key_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               kw = key_words.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= kw.data;
               req_tuser <= kw.mode;
               req_tlast <= kw.last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      lookup_result_type r;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (lookup_q.size() == 0) begin
               $error("result word with nothing expected: %h", rsp_tdata);
               mismatch_count++;
            end else begin
               r = lookup_q.pop_front();
               if (rsp_tdata[0] !== r.member) begin
                  $error("member: expected %0d, got %0d", r.member, rsp_tdata[0]);
                  mismatch_count++;
               end
               if (rsp_tdata[1] !== r.accepted) begin
                  $error("accepted: expected %0d, got %0d", r.accepted, rsp_tdata[1]);
                  mismatch_count++;
               end
               if (rsp_tdata[33:2] !== r.count) begin
                  $error("item_count: expected %0d, got %0d", r.count, rsp_tdata[33:2]);
                  mismatch_count++;
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   function automatic logic [7:0] key_byte_at(input int seed, input int j);
      logic [31:0] x;
      x = (seed ^ (j * 32'h9e3779b1)) * 32'h85ebca6b;
      x = x ^ (x >> 13);
      return x[23:16] ^ x[7:0];
   endfunction

   task automatic queue_key(input logic [1:0] mode, input int seed, input int len);
      key_word_type kw;
      for (int j = 0; j < len; j++) begin
         kw.last = (j == len - 1);
         kw.mode = kw.last ? mode : 2'($urandom_range(3));
         kw.data = key_byte_at(seed, j);
         key_words.push_back(kw);
      end
      if (mode == MODE_ADD) begin
         added_seed.push_back(seed);
         added_len.push_back(len);
      end
   endtask

   task automatic queue_raw(input logic [1:0] mode, input logic [7:0] data,
                            input logic last);
      key_word_type kw;
      kw.mode = mode;
      kw.data = data;
      kw.last = last;
      key_words.push_back(kw);
   endtask

   task automatic drain();
      do @(posedge clock);
      while (key_words.size() != 0 || req_tvalid || lookup_q.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_AW-1:0] addr, input logic [31:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= data;
      case (addr)
         CSR_BIT_COUNT:   cfg_bits = data[16:0];
         CSR_PROBE_COUNT: cfg_probes = data[4:0];
         CSR_CAPACITY:    cfg_capacity = data;
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic random_keys(input int nbytes, input int clears);
      int queued, r, len, seed, pick;
      logic [1:0] mode;
      queued = 0;
      while (queued < nbytes) begin
         r = $urandom_range(99);
         if (r < 45) mode = MODE_ADD;
         else if (r < 85) mode = MODE_TEST;
         else if (r < 93 || clears == 0) mode = MODE_NOP;
         else begin
            mode = MODE_CLEAR;
            clears--;
         end
         r = $urandom_range(99);
         len = (r < 70) ? $urandom_range(6, 1) : (r < 95) ? $urandom_range(70, 7)
               : $urandom_range(130, 100);
         seed = $urandom;
         if (mode == MODE_TEST && added_seed.size() > 0 && $urandom_range(99) < 60) begin
            pick = $urandom_range(added_seed.size() - 1);
            seed = added_seed[pick];
            len = added_len[pick];
         end
         queue_key(mode, seed, len);
         queued += len;
      end
      drain();
   endtask

   task automatic run_phase(input int send_pct, input int recv_pct, input logic [31:0] nbits,
                            input logic [31:0] nprobes, input logic [31:0] cap,
                            input int nbytes, input int clears);
      csr_write(CSR_BIT_COUNT, nbits);
      csr_write(CSR_PROBE_COUNT, nprobes);
      csr_write(CSR_CAPACITY, cap);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      random_keys(nbytes, clears);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      queue_raw(MODE_TEST, 8'h00, 1'b1);
      queue_key(MODE_ADD, 0, 1);
      queue_raw(MODE_ADD, 8'h00, 1'b1);
      queue_raw(MODE_TEST, 8'h00, 1'b1);
      queue_raw(MODE_TEST, 8'hff, 1'b1);
      queue_raw(MODE_ADD, 8'hff, 1'b0);
      queue_raw(MODE_NOP, 8'h5a, 1'b1);
      queue_raw(MODE_TEST, 8'hff, 1'b0);
      queue_raw(MODE_CLEAR, 8'ha5, 1'b0);
      queue_raw(MODE_TEST, 8'h5a, 1'b1);
      queue_raw(MODE_NOP, 8'hff, 1'b1);
      queue_raw(MODE_CLEAR, 8'h01, 1'b1);
      queue_raw(MODE_TEST, 8'h00, 1'b1);
      queue_raw(MODE_ADD, 8'h80, 1'b1);
      queue_raw(MODE_TEST, 8'h80, 1'b1);
      drain();
      run_phase(84, 0, 32'd1, 32'd2, 32'd3, 220, 0);
      run_phase(0, 84, 32'd0, 32'd0, 32'd0, 150, 0);
      run_phase(14, 14, 32'h1ffff, 32'd31, 32'hffffffff, 230, 1);
      run_phase(0, 0, $urandom_range(5000, 100), 32'd17, 32'd40, 200, 0);
      run_phase(84, 0, 32'd65536, 32'd1, 32'd4096, 180, 0);
      run_phase(0, 84, $urandom_range(65535, 2), 32'd16, $urandom_range(200, 60), 180, 1);
      run_phase(14, 14, 32'd2, $urandom_range(15, 3), $urandom, 180, 0);
      if (mismatch_count == 0 && lookup_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

### filelist.f
hdl/bfsh_pkg.sv
hdl/bfsh_sha.sv
hdl/bfsh_mod.sv
hdl/bloom_filter_sha256_double_hash.sv
tb/bloom_filter_sha256_double_hash_test.sv
